FILE: rtl/dlq_pkg.sv
// Shared types and constants for the dual linear queue unit.
`default_nettype none

package dlq_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned QueueDepthDef = 8;
  localparam int unsigned DataWidthDef  = 32;
  localparam int unsigned QueueDepthMax = 64;

  // Field widths fixed by the interface
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 8;

  // Slot index width large enough for the deepest supported queue
  localparam int unsigned QIdxW = $clog2(QueueDepthMax);

  // Depths of the command queue and the result queue
  localparam int unsigned CmdFifoDepth = 2;
  localparam int unsigned ResFifoDepth = 2;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_MODIFY  = 2'd2,
    CMD_DISPLAY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // What the back end has to do for one classified command
  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,   // status-only result, no memory access
    OP_WRITE  = 2'd1,   // write one slot, then an ok result
    OP_READ   = 2'd2    // read slots first_idx..last_idx, one result each
  } op_kind_e;

  typedef struct packed {
    cmd_e                     command;
    logic                     queue_select;
    logic [PosW-1:0]          position;
    logic signed [ValueW-1:0] value;
  } item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [ValueW-1:0] data;
    logic                     last;
  } result_t;

  typedef struct packed {
    op_kind_e          kind;
    status_e           status;
    logic              qsel;
    logic [QIdxW-1:0]  first_idx;
    logic [QIdxW-1:0]  last_idx;
    logic [ValueW-1:0] wdata;
  } op_t;

endpackage

`default_nettype wire

FILE: rtl/dlq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dlq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/dlq_fifo.sv
// Small register FIFO used for the command queue and the result queue.
`default_nettype none

module dlq_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           data_i,
  input  wire logic                       pop_i,
  output logic      [WIDTH-1:0]           data_o,
  output logic                            full_o,
  output logic                            empty_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = entry_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dlq_front.sv
// Front end: accepts commands, owns the queue pointers and classifies each command.
`default_nettype none

module dlq_front #(
  parameter int unsigned QUEUE_DEPTH = dlq_pkg::QueueDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire dlq_pkg::item_t item_i,
  input  wire logic          cmd_full_i,
  output logic               op_push_o,
  output dlq_pkg::op_t       op_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned SumW = dlq_pkg::PosW + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);

  logic [IdxW-1:0] head_q [2];
  logic [IdxW-1:0] head_d [2];
  logic [IdxW-1:0] tail_q [2];
  logic [IdxW-1:0] tail_d [2];
  logic [1:0]      empty_q, empty_d;

  logic            accept;
  logic            sel;
  logic [IdxW-1:0] head_cur, tail_cur;
  logic            empty_cur;
  logic [SumW-1:0] pos_sum;
  logic            pos_bad;

  assign accept    = push_i & ~cmd_full_i;
  assign op_push_o = accept;

  assign sel       = item_i.queue_select;
  assign head_cur  = head_q[sel];
  assign tail_cur  = tail_q[sel];
  assign empty_cur = empty_q[sel];

  // Slot addressed by a 1-based position from the head
  assign pos_sum = SumW'(item_i.position) + SumW'(head_cur) - SumW'(1);
  assign pos_bad = (item_i.position == '0) || (pos_sum > SumW'(tail_cur));

  // Classification and pointer update
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;

    op_o.kind      = dlq_pkg::OP_STATUS;
    op_o.status    = dlq_pkg::ST_OK;
    op_o.qsel      = sel;
    op_o.first_idx = dlq_pkg::QIdxW'(head_cur);
    op_o.last_idx  = dlq_pkg::QIdxW'(head_cur);
    op_o.wdata     = item_i.value;

    unique case (item_i.command)
      dlq_pkg::CMD_INSERT: begin
        if (!empty_cur && (tail_cur == LastIdx)) begin
          op_o.status = dlq_pkg::ST_FULL;
        end else if (empty_cur) begin
          // First entry restarts both pointers at slot zero
          op_o.kind      = dlq_pkg::OP_WRITE;
          op_o.first_idx = '0;
          head_d[sel]    = '0;
          tail_d[sel]    = '0;
          empty_d[sel]   = 1'b0;
        end else begin
          op_o.kind      = dlq_pkg::OP_WRITE;
          op_o.first_idx = dlq_pkg::QIdxW'(tail_cur + 1'b1);
          tail_d[sel]    = tail_cur + 1'b1;
        end
      end
      dlq_pkg::CMD_DELETE: begin
        if (empty_cur) begin
          op_o.status = dlq_pkg::ST_EMPTY;
        end else begin
          op_o.kind = dlq_pkg::OP_READ;
          if (head_cur == tail_cur) begin
            head_d[sel]  = '0;
            tail_d[sel]  = '0;
            empty_d[sel] = 1'b1;
          end else begin
            head_d[sel] = head_cur + 1'b1;
          end
        end
      end
      dlq_pkg::CMD_MODIFY: begin
        if (empty_cur) begin
          op_o.status = dlq_pkg::ST_EMPTY;
        end else if (pos_bad) begin
          op_o.status = dlq_pkg::ST_BADPOS;
        end else begin
          op_o.kind      = dlq_pkg::OP_WRITE;
          op_o.first_idx = dlq_pkg::QIdxW'(pos_sum[IdxW-1:0]);
        end
      end
      dlq_pkg::CMD_DISPLAY: begin
        if (empty_cur) begin
          op_o.status = dlq_pkg::ST_EMPTY;
        end else begin
          op_o.kind     = dlq_pkg::OP_READ;
          op_o.last_idx = dlq_pkg::QIdxW'(tail_cur);
        end
      end
      default: begin
        op_o.status = dlq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '{default: '0};
      tail_q  <= '{default: '0};
      empty_q <= '1;
    end else if (accept) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dlq_back.sv
// Back end: carries out classified commands against the slot memory and forms results.
`default_nettype none

module dlq_back #(
  parameter int unsigned QUEUE_DEPTH = dlq_pkg::QueueDepthDef,
  parameter int unsigned DATA_WIDTH  = dlq_pkg::DataWidthDef,
  parameter int unsigned RES_DEPTH   = dlq_pkg::ResFifoDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           op_empty_i,
  input  wire dlq_pkg::op_t                   op_i,
  output logic                                op_pop_o,
  input  wire logic [$clog2(RES_DEPTH+1)-1:0] res_count_i,
  output logic                                res_push_o,
  output dlq_pkg::result_t                    res_o
);

  localparam int unsigned IdxW     = $clog2(QUEUE_DEPTH);
  // Queue select on top of the slot index; unused rows when the depth is not a power of two
  localparam int unsigned AddrW    = IdxW + 1;
  localparam int unsigned RamDepth = 2 ** AddrW;
  localparam int unsigned CntW     = $clog2(RES_DEPTH + 1);
  localparam int unsigned ValueW   = dlq_pkg::ValueW;

  logic                  walk_act_q, walk_act_d;
  logic [IdxW-1:0]       walk_q, walk_d;
  logic                  res_vld_q, res_vld_d;
  dlq_pkg::status_e      res_status_q, res_status_d;
  logic                  res_last_q, res_last_d;
  logic                  res_ram_q, res_ram_d;

  logic [IdxW-1:0]       cur_idx;
  logic                  cur_last;
  logic                  room;
  logic                  go;
  logic                  ram_we, ram_re;
  logic [AddrW-1:0]      ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [ValueW-1:0]     rd_ext;

  assign cur_idx  = walk_act_q ? walk_q : op_i.first_idx[IdxW-1:0];
  assign cur_last = (cur_idx == op_i.last_idx[IdxW-1:0]);
  assign ram_addr = {op_i.qsel, cur_idx};

  // Issue only with a result slot reserved, counting the one in the stage register
  assign room = ((CntW+1)'(res_count_i) + (CntW+1)'(res_vld_q)) < (CntW+1)'(RES_DEPTH);
  assign go   = ~op_empty_i & room;

  // Step sequencing
  always_comb begin
    walk_act_d   = walk_act_q;
    walk_d       = walk_q;
    res_vld_d    = go;
    res_status_d = dlq_pkg::ST_OK;
    res_last_d   = 1'b1;
    res_ram_d    = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    op_pop_o     = 1'b0;

    case (op_i.kind)
      dlq_pkg::OP_WRITE: begin
        ram_we   = go;
        op_pop_o = go;
      end
      dlq_pkg::OP_READ: begin
        ram_re     = go;
        res_ram_d  = 1'b1;
        res_last_d = cur_last;
        if (go) begin
          if (cur_last) begin
            op_pop_o   = 1'b1;
            walk_act_d = 1'b0;
          end else begin
            walk_act_d = 1'b1;
            walk_d     = cur_idx + 1'b1;
          end
        end
      end
      default: begin
        res_status_d = op_i.status;
        op_pop_o     = go;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_act_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      walk_act_q <= walk_act_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q       <= walk_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
    res_ram_q    <= res_ram_d;
  end

  // Word width conversion between the 32-bit value field and the stored width
  if (DATA_WIDTH >= ValueW) begin : g_wide
    assign ram_wdata = DATA_WIDTH'(op_i.wdata);
    assign rd_ext    = ram_rdata[ValueW-1:0];
  end else begin : g_narrow
    assign ram_wdata = op_i.wdata[DATA_WIDTH-1:0];
    assign rd_ext    = {{(ValueW - DATA_WIDTH){ram_rdata[DATA_WIDTH-1]}}, ram_rdata};
  end

  dlq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // Result stage: read data arrives in the cycle after the read is issued
  assign res_push_o   = res_vld_q;
  assign res_o.status = res_status_q;
  assign res_o.data   = res_ram_q ? rd_ext : '0;
  assign res_o.last   = res_last_q;

endmodule

`default_nettype wire

FILE: rtl/dual_linear_queue_unit.sv
// Top level of the dual linear queue unit.
`default_nettype none

// Two independent linear (non-wrapping) queues of QUEUE_DEPTH words each, sharing one
// slot memory. Each command names a queue: insert, delete, modify by 1-based position,
// or display. A queue regains space only when it drains empty. Commands are taken at
// up to one per cycle while the two-entry command queue has space; the front end
// updates the pointers at once and the back end then issues at most one result per
// cycle on the single memory port. Insert, delete, modify and every error give one
// result; a display of n held entries gives n, with last on the final one. The
// two-entry result queue, with the result stage register counted against it, lets
// no more than two results be in flight, so even with the consumer popping every
// cycle the back end pauses after each pair of results. When nothing stalls, the first
// result of a command passes through the command queue, the result stage register and
// the result queue to reach the result ports. No clearing pass is needed after reset.
module dual_linear_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = dlq_pkg::QueueDepthDef,
  parameter int unsigned DATA_WIDTH  = dlq_pkg::DataWidthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire dlq_pkg::item_t   item_i,
  output logic                  empty,
  input  wire logic             pop,
  output dlq_pkg::result_t      result_o
);

  localparam int unsigned OpW  = $bits(dlq_pkg::op_t);
  localparam int unsigned ResW = $bits(dlq_pkg::result_t);
  localparam int unsigned CmdCntW = $clog2(dlq_pkg::CmdFifoDepth + 1);
  localparam int unsigned ResCntW = $clog2(dlq_pkg::ResFifoDepth + 1);

  logic                op_push;
  dlq_pkg::op_t        op_in, op_head;
  logic [OpW-1:0]      op_head_bits;
  logic                op_empty;
  logic                op_pop;
  logic [CmdCntW-1:0]  cmd_count;

  logic                res_push;
  dlq_pkg::result_t    res_in;
  logic [ResW-1:0]     res_out_bits;
  logic [ResCntW-1:0]  res_count;
  logic                res_full;

  dlq_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .cmd_full_i (full),
    .op_push_o  (op_push),
    .op_o       (op_in)
  );

  // Command queue between front and back
  dlq_fifo #(
    .WIDTH (OpW),
    .DEPTH (dlq_pkg::CmdFifoDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  (op_in),
    .pop_i   (op_pop),
    .data_o  (op_head_bits),
    .full_o  (full),
    .empty_o (op_empty),
    .count_o (cmd_count)
  );

  assign op_head = op_head_bits;

  dlq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH),
    .RES_DEPTH   (dlq_pkg::ResFifoDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_empty_i  (op_empty),
    .op_i        (op_head),
    .op_pop_o    (op_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue towards the consumer; space is reserved before each push
  dlq_fifo #(
    .WIDTH (ResW),
    .DEPTH (dlq_pkg::ResFifoDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push & ~res_full),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out_bits),
    .full_o  (res_full),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign result_o = res_out_bits;

endmodule

`default_nettype wire

FILE: sim/tb_dual_linear_queue_unit.sv
// Self-checking testbench for the dual linear queue unit.
`default_nettype none

module tb_dual_linear_queue_unit;

  localparam int unsigned DEPTH       = dlq_pkg::QueueDepthDef;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_ITEMS  = 400;
  localparam int unsigned MAX_PRINTS  = 100;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push   = 1'b0;
  logic             pop    = 1'b0;
  dlq_pkg::item_t   item_i = '0;
  logic             full;
  logic             empty;
  dlq_pkg::result_t result_o;

  // Pending commands for the driver, and results the queues are due to give
  dlq_pkg::item_t   cmd_backlog[$];
  dlq_pkg::result_t due_results[$];

  // Shadow copy of both queues
  logic signed [dlq_pkg::ValueW-1:0] q_store [2][DEPTH];
  int unsigned q_head  [2];
  int unsigned q_tail  [2];
  logic        q_empty [2];

  int unsigned      n_accepted = 0;
  int unsigned      n_errors   = 0;
  int unsigned      cycles     = 0;
  logic             steady;
  dlq_pkg::result_t want;

  dual_linear_queue_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Work out the results of one command and update the shadow queues
  task automatic apply_queue_command(input dlq_pkg::item_t it);
    int unsigned      sel;
    int unsigned      idx;
    dlq_pkg::result_t r;
    sel      = {31'b0, it.queue_select};
    r.status = dlq_pkg::ST_OK;
    r.data   = '0;
    r.last   = 1'b1;
    case (it.command)
      dlq_pkg::CMD_INSERT: begin
        if (!q_empty[sel] && q_tail[sel] >= DEPTH - 1) begin
          r.status = dlq_pkg::ST_FULL;
        end else begin
          if (q_empty[sel]) begin
            q_head[sel]  = 0;
            q_tail[sel]  = 0;
            q_empty[sel] = 1'b0;
          end else begin
            q_tail[sel]++;
          end
          q_store[sel][q_tail[sel]] = it.value;
        end
        due_results.push_back(r);
      end
      dlq_pkg::CMD_DELETE: begin
        if (q_empty[sel]) begin
          r.status = dlq_pkg::ST_EMPTY;
        end else begin
          r.data = q_store[sel][q_head[sel]];
          if (q_head[sel] == q_tail[sel]) begin
            q_head[sel]  = 0;
            q_tail[sel]  = 0;
            q_empty[sel] = 1'b1;
          end else begin
            q_head[sel]++;
          end
        end
        due_results.push_back(r);
      end
      dlq_pkg::CMD_MODIFY: begin
        if (q_empty[sel]) begin
          r.status = dlq_pkg::ST_EMPTY;
        end else if (it.position == 0 ||
                     q_head[sel] + it.position - 1 > q_tail[sel]) begin
          r.status = dlq_pkg::ST_BADPOS;
        end else begin
          q_store[sel][q_head[sel] + it.position - 1] = it.value;
        end
        due_results.push_back(r);
      end
      default: begin
        if (q_empty[sel]) begin
          r.status = dlq_pkg::ST_EMPTY;
          due_results.push_back(r);
        end else begin
          for (idx = q_head[sel]; idx <= q_tail[sel]; idx++) begin
            r.data = q_store[sel][idx];
            r.last = (idx == q_tail[sel]);
            due_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (n_errors < MAX_PRINTS) $display("mismatch @%0d: %s", cycles, msg);
    n_errors++;
  endtask

  task automatic queue_item(input dlq_pkg::cmd_e c, input logic sel,
                            input logic [dlq_pkg::PosW-1:0] pos,
                            input logic [dlq_pkg::ValueW-1:0] val);
    dlq_pkg::item_t it;
    it.command      = c;
    it.queue_select = sel;
    it.position     = pos;
    it.value        = val;
    cmd_backlog.push_back(it);
  endtask

  // Hold off the sender until every pending command has been taken and answered
  task automatic drain();
    do @(posedge clk_i);
    while (cmd_backlog.size() != 0 || push || due_results.size() != 0);
  endtask

  // Long stretch in which the driver and the monitor offer transfers without random gaps
  assign steady = (n_accepted >= 250 && n_accepted < 330);

  // Driver: predicts on each accepted transfer, then offers the next command
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push   <= 1'b0;
      item_i <= '0;
      q_head  = '{0, 0};
      q_tail  = '{0, 0};
      q_empty = '{1'b1, 1'b1};
    end else begin
      if (push && !full) begin
        apply_queue_command(item_i);
        n_accepted++;
      end
      if (!push || !full) begin
        if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
          item_i <= cmd_backlog.pop_front();
          push   <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d data=%h last=%b",
                                    result_o.status, result_o.data, result_o.last));
        end else begin
          want = due_results.pop_front();
          if (result_o.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", result_o.status, want.status));
          if (result_o.data !== want.data)
            report_mismatch($sformatf("data %h, want %h", result_o.data, want.data));
          if (result_o.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", result_o.last, want.last));
        end
      end
      pop <= steady || ($urandom_range(99) >= 33);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus
  initial begin
    dlq_pkg::item_t it;
    int unsigned    pick;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty queue cases
    queue_item(dlq_pkg::CMD_DISPLAY, 1'b0, 8'd0, 32'd0);
    queue_item(dlq_pkg::CMD_DELETE,  1'b0, 8'd0, 32'd0);
    queue_item(dlq_pkg::CMD_MODIFY,  1'b0, 8'd1, 32'h1234_5678);
    // Extreme values, then bad positions and a good modify
    queue_item(dlq_pkg::CMD_INSERT,  1'b0, 8'd0, 32'h8000_0000);
    queue_item(dlq_pkg::CMD_INSERT,  1'b0, 8'd0, 32'h7fff_ffff);
    queue_item(dlq_pkg::CMD_INSERT,  1'b0, 8'd0, 32'hffff_ffff);
    queue_item(dlq_pkg::CMD_MODIFY,  1'b0, 8'd0, 32'h0000_0001);
    queue_item(dlq_pkg::CMD_MODIFY,  1'b0, 8'd4, 32'h0000_0002);
    queue_item(dlq_pkg::CMD_MODIFY,  1'b0, 8'd255, 32'h0000_0003);
    queue_item(dlq_pkg::CMD_MODIFY,  1'b0, 8'd3, 32'h5a5a_5a5a);
    queue_item(dlq_pkg::CMD_DISPLAY, 1'b0, 8'd0, 32'd0);
    // Fill to the last slot, then insert when full
    for (int k = 0; k < 5; k++) queue_item(dlq_pkg::CMD_INSERT, 1'b0, 8'd0, $urandom);
    queue_item(dlq_pkg::CMD_INSERT,  1'b0, 8'd0, 32'hdead_beef);
    // Full persists after the head moves forward
    queue_item(dlq_pkg::CMD_DELETE,  1'b0, 8'd0, 32'd0);
    queue_item(dlq_pkg::CMD_INSERT,  1'b0, 8'd0, 32'hcafe_f00d);
    queue_item(dlq_pkg::CMD_DISPLAY, 1'b0, 8'd0, 32'd0);
    // Second queue: deleting the only entry empties it
    queue_item(dlq_pkg::CMD_INSERT,  1'b1, 8'd0, 32'd0);
    queue_item(dlq_pkg::CMD_DELETE,  1'b1, 8'd0, 32'd0);
    queue_item(dlq_pkg::CMD_DELETE,  1'b1, 8'd0, 32'd0);
    queue_item(dlq_pkg::CMD_DISPLAY, 1'b1, 8'd0, 32'd0);
    queue_item(dlq_pkg::CMD_MODIFY,  1'b1, 8'd1, 32'd0);
    drain();

    // Random traffic, biased towards inserts so queues fill and go full
    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 38)      it.command = dlq_pkg::CMD_INSERT;
      else if (pick < 62) it.command = dlq_pkg::CMD_DELETE;
      else if (pick < 80) it.command = dlq_pkg::CMD_MODIFY;
      else                it.command = dlq_pkg::CMD_DISPLAY;
      it.queue_select = 1'($urandom_range(1));
      it.position     = 8'(($urandom_range(99) < 85) ? $urandom_range(9)
                                                     : $urandom_range(255));
      pick = $urandom_range(19);
      if (pick == 0)      it.value = 32'h8000_0000;
      else if (pick == 1) it.value = 32'h7fff_ffff;
      else if (pick == 2) it.value = 32'hffff_ffff;
      else if (pick == 3) it.value = '0;
      else                it.value = $urandom;
      cmd_backlog.push_back(it);
      // Sender holds off mid-run until everything has come back
      if (n == RAND_ITEMS / 2) drain();
    end
    drain();
    repeat (30) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/dlq_pkg.sv
rtl/dlq_ram.sv
rtl/dlq_fifo.sv
rtl/dlq_front.sv
rtl/dlq_back.sv
rtl/dual_linear_queue_unit.sv
sim/tb_dual_linear_queue_unit.sv
